[hw/rtl/cgi_pkg.sv]
// Shared types and constants for the colour gradient interpolator.
`timescale 1ns / 1ps
package cgi_pkg;
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned POS_W = FRAC_BITS + 1;
  localparam int unsigned CH_W  = 8;
  localparam int unsigned ST_W  = 3;

  localparam logic [ST_W-1:0] ST_COLOR_OK  = 3'd0;
  localparam logic [ST_W-1:0] ST_MALFORMED = 3'd1;
  localparam logic [ST_W-1:0] ST_ADD_OK    = 3'd2;
  localparam logic [ST_W-1:0] ST_ADD_RANGE = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture the incoming request
    logic add_write; // append the captured frame
    logic scan_step; // examine the frame at the scan index
    logic div_start; // start the three channel divisions
    logic div_step;  // one quotient bit
    logic finish;    // form the result word
  } cgi_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic is_query;
    logic well_formed;
    logic scan_done;
    logic exact;
    logic need_blend;
    logic div_done;
  } cgi_stat_t;
endpackage

[hw/rtl/cgi_datapath.sv]
// Datapath: keyframe store, scan registers, blend arithmetic and result register.
`timescale 1ns / 1ps
module cgi_datapath #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cgi_pkg::cgi_cmd_t        cmd_bus,
  output cgi_pkg::cgi_stat_t       stat_bus,
  input  logic                     cmd,
  input  logic [cgi_pkg::POS_W-1:0] position,
  input  logic [cgi_pkg::CH_W-1:0] red_in,
  input  logic [cgi_pkg::CH_W-1:0] green_in,
  input  logic [cgi_pkg::CH_W-1:0] blue_in,
  output logic [cgi_pkg::CH_W-1:0] red_out,
  output logic [cgi_pkg::CH_W-1:0] green_out,
  output logic [cgi_pkg::CH_W-1:0] blue_out,
  output logic [cgi_pkg::ST_W-1:0] status,
  output logic                     well_formed
);
  localparam int unsigned IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_FRAMES + 1);
  localparam int unsigned PW    = cgi_pkg::POS_W;
  localparam int unsigned CW    = cgi_pkg::CH_W;
  localparam int unsigned NUM_W = CW + PW + 1;
  localparam int unsigned QB_W  = $clog2(NUM_W + 1);
  localparam logic [PW-1:0] POS_ONE = PW'(1) << cgi_pkg::FRAC_BITS;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

  logic [PW-1:0]   pos_mem [MAX_FRAMES];
  logic [3*CW-1:0] col_mem [MAX_FRAMES];

  logic [CNT_W-1:0] frame_count;
  logic [1:0]       zero_cnt, one_cnt;
  logic [1:0]       zero_cnt_next, one_cnt_next;
  logic             req_cmd;
  logic [PW-1:0]    req_pos;
  logic [3*CW-1:0]  req_col;
  logic [CNT_W-1:0] scan_idx;
  logic [CNT_W-1:0] rd_idx;
  logic             exact, have_lo, have_hi;
  logic [PW-1:0]    lo_p, hi_p;
  logic [3*CW-1:0]  lo_c, hi_c, ex_c;
  logic [NUM_W-1:0] rem [3];
  logic [NUM_W-1:0] num [3];
  logic [CW-1:0]    quo [3];
  logic [QB_W-1:0]  bit_cnt;
  logic [PW-1:0]    range_r;

  logic [PW-1:0]   fp;
  logic [3*CW-1:0] fc;
  logic            wf_now, pos_bad, tbl_full, add_ok;
  logic [PW-1:0]   p_clamp;

  assign wf_now   = (zero_cnt == 2'd1) && (one_cnt == 2'd1);
  assign pos_bad  = req_pos > POS_ONE;
  assign tbl_full = frame_count >= MAX_CNT;
  assign add_ok   = !pos_bad && !tbl_full;
  assign p_clamp  = pos_bad ? POS_ONE : req_pos;
  assign zero_cnt_next = (add_ok && req_pos == '0 && zero_cnt != 2'd2) ?
                         zero_cnt + 2'd1 : zero_cnt;
  assign one_cnt_next  = (add_ok && req_pos == POS_ONE && one_cnt != 2'd2) ?
                         one_cnt + 2'd1 : one_cnt;

  // The store is read one entry ahead so that fp and fc hold the entry at scan_idx.
  assign rd_idx = cmd_bus.load ? '0 :
                  (cmd_bus.scan_step ? scan_idx + CNT_W'(1) : scan_idx);

  assign stat_bus.is_query    = req_cmd;
  assign stat_bus.well_formed = wf_now;
  assign stat_bus.scan_done   = exact || (scan_idx >= frame_count);
  assign stat_bus.exact       = exact;
  assign stat_bus.need_blend  = have_lo && have_hi;
  assign stat_bus.div_done    = bit_cnt == '0;

  always_ff @(posedge clk) begin
    if (cmd_bus.add_write && add_ok) begin
      pos_mem[frame_count[IDX_W-1:0]] <= req_pos;
      col_mem[frame_count[IDX_W-1:0]] <= req_col;
    end
    fp <= pos_mem[rd_idx[IDX_W-1:0]];
    fc <= col_mem[rd_idx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_count <= '0;
      zero_cnt    <= '0;
      one_cnt     <= '0;
    end else if (cmd_bus.add_write && add_ok) begin
      frame_count <= frame_count + CNT_W'(1);
      zero_cnt    <= zero_cnt_next;
      one_cnt     <= one_cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.load) begin
      req_cmd  <= cmd;
      req_pos  <= position;
      req_col  <= {red_in, green_in, blue_in};
      scan_idx <= '0;
      exact    <= 1'b0;
      have_lo  <= 1'b0;
      have_hi  <= 1'b0;
    end else if (cmd_bus.scan_step) begin
      req_pos  <= p_clamp;
      scan_idx <= scan_idx + CNT_W'(1);
      if (fp == p_clamp) begin
        exact <= 1'b1;
        ex_c  <= fc;
      end else begin
        if (fp < p_clamp && (!have_lo || fp > lo_p)) begin
          have_lo <= 1'b1;
          lo_p    <= fp;
          lo_c    <= fc;
        end
        if (fp > p_clamp && (!have_hi || fp < hi_p)) begin
          have_hi <= 1'b1;
          hi_p    <= fp;
          hi_c    <= fc;
        end
      end
    end
  end

  // Restoring division, one quotient bit per cycle for all three channels.
  always_ff @(posedge clk) begin
    if (cmd_bus.div_start) begin
      range_r <= hi_p - lo_p;
      bit_cnt <= QB_W'(NUM_W);
      for (int i = 0; i < 3; i++) begin
        num[i] <= NUM_W'(lo_c[CW*(2-i) +: CW]) * NUM_W'(hi_p - req_pos)
                + NUM_W'(hi_c[CW*(2-i) +: CW]) * NUM_W'(req_pos - lo_p)
                + NUM_W'((hi_p - lo_p) >> 1);
        rem[i] <= '0;
        quo[i] <= '0;
      end
    end else if (cmd_bus.div_step) begin
      bit_cnt <= bit_cnt - QB_W'(1);
      for (int i = 0; i < 3; i++) begin
        logic [NUM_W:0] trial;
        trial = {rem[i], num[i][NUM_W-1]};
        num[i] <= num[i] << 1;
        if (trial >= (NUM_W+1)'(range_r)) begin
          rem[i] <= NUM_W'(trial - (NUM_W+1)'(range_r));
          quo[i] <= {quo[i][CW-2:0], 1'b1};
        end else begin
          rem[i] <= NUM_W'(trial);
          quo[i] <= {quo[i][CW-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_bus.finish) begin
      // An add reports the table shape as it stands after the add.
      well_formed <= req_cmd ? wf_now : ((zero_cnt_next == 2'd1) && (one_cnt_next == 2'd1));
      {red_out, green_out, blue_out} <= '0;
      if (!req_cmd) begin
        if (pos_bad)       status <= cgi_pkg::ST_ADD_RANGE;
        else if (tbl_full) status <= cgi_pkg::ST_FULL;
        else               status <= cgi_pkg::ST_ADD_OK;
      end else if (!wf_now) begin
        status <= cgi_pkg::ST_MALFORMED;
      end else begin
        status <= cgi_pkg::ST_COLOR_OK;
        if (exact) {red_out, green_out, blue_out} <= ex_c;
        else if (have_lo && have_hi) {red_out, green_out, blue_out} <= {quo[0], quo[1], quo[2]};
      end
    end
  end
endmodule

[hw/rtl/cgi_ctrl.sv]
// Controller: sequences each request through add, scan, divide and result.
`timescale 1ns / 1ps
module cgi_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output cgi_pkg::cgi_cmd_t  cmd_bus,
  input  cgi_pkg::cgi_stat_t stat_bus
);
  typedef enum logic [2:0] {S_IDLE, S_DISPATCH, S_SCAN, S_DIV, S_FINISH, S_HOLD} state_t;
  state_t state;

  // Accept when idle, or when the waiting result is taken this cycle.
  logic take;
  assign in_stall = !((state == S_IDLE) || (state == S_HOLD && !out_stall));
  assign take = in_valid && !in_stall;

  always_comb begin
    cmd_bus = '0;
    cmd_bus.load = take;
    unique case (state)
      S_DISPATCH: begin
        if (!stat_bus.is_query) begin
          cmd_bus.add_write = 1'b1;
          cmd_bus.finish    = 1'b1;
        end else if (!stat_bus.well_formed) begin
          cmd_bus.finish = 1'b1;
        end
      end
      S_SCAN: begin
        if (stat_bus.scan_done) begin
          if (stat_bus.exact || !stat_bus.need_blend) cmd_bus.finish = 1'b1;
          else cmd_bus.div_start = 1'b1;
        end else begin
          cmd_bus.scan_step = 1'b1;
        end
      end
      S_DIV: begin
        if (stat_bus.div_done) cmd_bus.finish = 1'b1;
        else cmd_bus.div_step = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE:     if (take) state <= S_DISPATCH;
        S_DISPATCH: state <= (!stat_bus.is_query || !stat_bus.well_formed) ? S_HOLD : S_SCAN;
        S_SCAN: begin
          if (stat_bus.scan_done)
            state <= (stat_bus.exact || !stat_bus.need_blend) ? S_HOLD : S_DIV;
        end
        S_DIV:    if (stat_bus.div_done) state <= S_HOLD;
        S_FINISH: state <= S_HOLD;
        S_HOLD: begin
          if (!out_stall) state <= take ? S_DISPATCH : S_IDLE;
        end
        default:  state <= S_IDLE;
      endcase
      if (cmd_bus.finish) out_valid <= 1'b1;
      else if (state == S_HOLD && !out_stall) out_valid <= 1'b0;
    end
  end
endmodule

[hw/rtl/color_gradient_interpolator.sv]
// Top level of the colour gradient interpolator.
`timescale 1ns / 1ps
// A keyframe colour ramp. An add request appends a frame (position and RGB colour) to
// a table of MAX_FRAMES entries; a query request returns the colour at a position,
// either the exact colour of the earliest frame there or a rounded linear blend of the
// nearest frames below and above. Positions are unsigned fixed point with sixteen
// fraction bits. Queries answer only while the table holds exactly one frame at 0 and
// one at 1.0, otherwise they return black with a malformed status.
// Each request yields exactly one result. An add, like a malformed query, is finished in
// the dispatch state; a query on a well-formed table scans the stored frames (the table
// is read one entry a cycle) and then runs the bit-serial division when a blend is
// needed. A new request is accepted in the cycle its predecessor's result is taken.
// The table is not cleared at reset; only written entries are ever used.
module color_gradient_interpolator #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        cmd,
  input  logic [cgi_pkg::POS_W-1:0] position,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  red_out,
  output logic [7:0]  green_out,
  output logic [7:0]  blue_out,
  output logic [2:0]  status,
  output logic        well_formed
);
  cgi_pkg::cgi_cmd_t  cmd_bus;
  cgi_pkg::cgi_stat_t stat_bus;

  cgi_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd_bus, .stat_bus
  );

  cgi_datapath #(.MAX_FRAMES(MAX_FRAMES)) u_dp (
    .clk, .rst, .cmd_bus, .stat_bus, .cmd, .position, .red_in, .green_in, .blue_in,
    .red_out, .green_out, .blue_out, .status, .well_formed
  );
endmodule

[hw/rtl/cgi_checker.sv]
// Port-level checker for the colour gradient interpolator, with its bind.
`timescale 1ns / 1ps
module cgi_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic [2:0] status,
  input logic       well_formed
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("stalled result changed");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status <= cgi_pkg::ST_FULL)
    else $error("status code out of range");
  a_black: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cgi_pkg::ST_COLOR_OK |->
      red_out == 8'd0 && green_out == 8'd0 && blue_out == 8'd0)
    else $error("colour on non-colour result");
  a_malformed: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == cgi_pkg::ST_MALFORMED |-> !well_formed)
    else $error("malformed with well-formed flag");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");
endmodule

bind color_gradient_interpolator cgi_checker u_cgi_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall,
  .red_out, .green_out, .blue_out, .status, .well_formed
);
